// File: rtl/core/pmm_pkg.sv
// Shared constants, codes and control/status types for the paged memory manager.
package pmm_pkg;

    localparam int OFFSET_BITS_DEF   = 8;
    localparam int ADDRESS_BITS_DEF  = 16;
    localparam int FRAME_COUNT_DEF   = 256;
    localparam int PROCESS_SLOTS_DEF = 16;

    localparam logic [16:0] INIT_BREAK = 17'd256;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_READ  = 2'd2,
        OP_WRITE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_REFUSED  = 2'd1,
        ST_UNMAPPED = 2'd2
    } status_t;

    typedef struct packed {
        logic clear;
        logic latch;
        logic decode;
        logic xlat;
        logic mem_cap;
        logic scan_chk;
        logic link_end;
        logic free_rd;
        logic free_chk;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        op_t  op;
        logic pid_ok;
        logic alloc_ok;
        logic map_valid;
        logic scan_last;
        logic free_last;
    } sts_t;

endpackage

// File: rtl/core/pmm_datapath.sv
// Datapath: request registers, break pointers, frame/map/link tables and byte RAM.
module pmm_datapath
    import pmm_pkg::*;
#(
    parameter int OFFSET_BITS   = OFFSET_BITS_DEF,
    parameter int ADDRESS_BITS  = ADDRESS_BITS_DEF,
    parameter int FRAME_COUNT   = FRAME_COUNT_DEF,
    parameter int PROCESS_SLOTS = PROCESS_SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [16:0] cfg_data,
    input  logic [1:0]  op,
    input  logic [3:0]  pid,
    input  logic [16:0] size,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    input  cmd_t        cmd,
    output sts_t        sts,
    output logic [1:0]  status,
    output logic [15:0] region_start,
    output logic [7:0]  read_byte
);

    localparam int FRAME_BITS = $clog2(FRAME_COUNT);
    localparam int VPN_BITS   = ADDRESS_BITS - OFFSET_BITS;
    localparam int PID_BITS   = $clog2(PROCESS_SLOTS);
    localparam int RAM_AW     = FRAME_BITS + OFFSET_BITS;
    localparam int RAM_DEPTH  = FRAME_COUNT << OFFSET_BITS;
    localparam int MAP_AW     = PID_BITS + VPN_BITS;
    localparam int MAP_DEPTH  = 1 << MAP_AW;
    localparam int CLR_DEPTH0 = (RAM_DEPTH > MAP_DEPTH) ? RAM_DEPTH : MAP_DEPTH;
    localparam int CLR_DEPTH  = (CLR_DEPTH0 > FRAME_COUNT) ? CLR_DEPTH0 : FRAME_COUNT;
    localparam int CLR_BITS   = $clog2(CLR_DEPTH);
    localparam int BRK_BITS   = (RAM_AW + 1 > 17) ? RAM_AW + 1 : 17;
    localparam int PG_BITS    = 18 - OFFSET_BITS;
    localparam int CNT_BITS   = FRAME_BITS + 1;
    localparam int PAGE_BYTES = 1 << OFFSET_BITS;

    // memories
    logic [7:0]            ram_mem   [RAM_DEPTH];
    logic [FRAME_BITS:0]   map_mem   [MAP_DEPTH];
    logic [3:0]            owner_mem [FRAME_COUNT];
    logic [FRAME_BITS:0]   link_mem  [FRAME_COUNT];

    logic [BRK_BITS-1:0]   brk_reg [PROCESS_SLOTS];
    logic [CNT_BITS-1:0]   free_cnt_reg;
    logic [CLR_BITS-1:0]   clr_cnt_reg;

    op_t                   op_reg;
    logic [3:0]            pid_reg;
    logic [PG_BITS-1:0]    pages_reg;
    logic [ADDRESS_BITS-1:0] vaddr_reg;
    logic [7:0]            wdata_reg;
    logic [FRAME_BITS-1:0] frame_reg;
    logic [FRAME_BITS-1:0] prev_reg;
    logic [FRAME_BITS-1:0] k_reg;
    logic [CNT_BITS-1:0]   n_reg;
    logic [VPN_BITS-1:0]   vpn_reg;
    logic [1:0]            status_reg;
    logic [15:0]           region_reg;
    logic [7:0]            rbyte_reg;

    logic [FRAME_BITS:0]   map_q;
    logic [3:0]            owner_q;
    logic [FRAME_BITS:0]   link_q;
    logic [7:0]            ram_q;

    logic [PID_BITS-1:0]   pid_idx;
    logic                  pid_ok;
    logic [BRK_BITS-1:0]   brk_cur;
    logic [31:0]           alloc_sum;
    logic                  alloc_ok;
    logic [VPN_BITS-1:0]   vpn_in;
    logic [RAM_AW-1:0]     ram_addr;
    logic                  owner_free;

    logic                  map_we;
    logic [MAP_AW-1:0]     map_waddr;
    logic [FRAME_BITS:0]   map_wdata;
    logic                  owner_we;
    logic [3:0]            owner_wdata;
    logic [FRAME_BITS-1:0] owner_waddr;
    logic                  link_we;
    logic [FRAME_BITS:0]   link_wdata;
    logic                  ram_we;
    logic [RAM_AW-1:0]     ram_waddr;
    logic [7:0]            ram_wdata;

    assign pid_idx    = PID_BITS'(pid_reg);
    assign pid_ok     = (pid_reg != 4'd0) && (32'(pid_reg) < PROCESS_SLOTS);
    assign brk_cur    = brk_reg[pid_idx];
    assign alloc_sum  = 32'(brk_cur) + (32'(pages_reg) << OFFSET_BITS);
    assign alloc_ok   = pid_ok && (pages_reg != '0) &&
                        (32'(free_cnt_reg) >= 32'(pages_reg)) &&
                        (alloc_sum <= 32'(RAM_DEPTH));
    assign vpn_in     = vaddr_reg[ADDRESS_BITS-1:OFFSET_BITS];
    assign ram_addr   = {map_q[FRAME_BITS-1:0], vaddr_reg[OFFSET_BITS-1:0]};
    assign owner_free = (owner_q == 4'd0);

    assign sts.clear_done = (clr_cnt_reg == CLR_BITS'(CLR_DEPTH - 1));
    assign sts.op         = op_reg;
    assign sts.pid_ok     = pid_ok;
    assign sts.alloc_ok   = alloc_ok;
    assign sts.map_valid  = map_q[FRAME_BITS];
    assign sts.scan_last  = owner_free && ((32'(n_reg) + 32'd1) == 32'(pages_reg));
    assign sts.free_last  = link_q[FRAME_BITS] || (k_reg == FRAME_BITS'(FRAME_COUNT - 1));

    assign status       = status_reg;
    assign region_start = region_reg;
    assign read_byte    = rbyte_reg;

    // write port selection
    always_comb
    begin
        map_we      = 1'b0;
        map_waddr   = {pid_idx, vpn_reg};
        map_wdata   = '0;
        owner_we    = 1'b0;
        owner_waddr = frame_reg;
        owner_wdata = 4'd0;
        link_we     = 1'b0;
        link_wdata  = {1'b0, frame_reg};
        ram_we      = 1'b0;
        ram_waddr   = ram_addr;
        ram_wdata   = wdata_reg;
        if (cmd.clear)
        begin
            map_we      = (32'(clr_cnt_reg) < MAP_DEPTH);
            map_waddr   = clr_cnt_reg[MAP_AW-1:0];
            owner_we    = (32'(clr_cnt_reg) < FRAME_COUNT);
            owner_waddr = clr_cnt_reg[FRAME_BITS-1:0];
            ram_we      = (32'(clr_cnt_reg) < RAM_DEPTH);
            ram_waddr   = clr_cnt_reg[RAM_AW-1:0];
            ram_wdata   = 8'd0;
        end
        if (cmd.scan_chk && owner_free)
        begin
            map_we      = 1'b1;
            map_wdata   = {1'b1, frame_reg};
            owner_we    = 1'b1;
            owner_wdata = pid_reg;
            link_we     = (n_reg != '0);
        end
        if (cmd.link_end)
        begin
            link_we    = 1'b1;
            link_wdata = {1'b1, {FRAME_BITS{1'b0}}};
        end
        if (cmd.free_rd)
            map_we = 1'b1;
        if (cmd.free_chk)
            owner_we = 1'b1;
        if (cmd.xlat && map_q[FRAME_BITS] && (op_reg == OP_WRITE))
            ram_we = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[map_waddr] <= map_wdata;
        map_q <= map_mem[{pid_idx, vpn_in}];
    end

    always_ff @(posedge clk)
    begin
        if (owner_we)
            owner_mem[owner_waddr] <= owner_wdata;
        owner_q <= owner_mem[frame_reg];
    end

    always_ff @(posedge clk)
    begin
        if (link_we)
            link_mem[prev_reg] <= link_wdata;
        link_q <= link_mem[frame_reg];
    end

    always_ff @(posedge clk)
    begin
        if (ram_we)
            ram_mem[ram_waddr] <= ram_wdata;
        ram_q <= ram_mem[ram_addr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PROCESS_SLOTS; i++)
                brk_reg[i] <= BRK_BITS'(INIT_BREAK);
            free_cnt_reg <= CNT_BITS'(FRAME_COUNT);
            clr_cnt_reg  <= '0;
        end
        else
        begin
            if (cmd.clear && !sts.clear_done)
                clr_cnt_reg <= clr_cnt_reg + CLR_BITS'(1);
            if (cfg_we)
            begin
                for (int i = 0; i < PROCESS_SLOTS; i++)
                    brk_reg[i] <= BRK_BITS'(cfg_data);
            end
            else if (cmd.decode && op_reg == OP_ALLOC && alloc_ok)
                brk_reg[pid_idx] <= BRK_BITS'(alloc_sum);
            if (cmd.scan_chk && owner_free)
                free_cnt_reg <= free_cnt_reg - CNT_BITS'(1);
            else if (cmd.free_chk && !owner_free)
                free_cnt_reg <= free_cnt_reg + CNT_BITS'(1);
        end
    end

    // request and walk registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg     <= op_t'(op);
            pid_reg    <= pid;
            pages_reg  <= PG_BITS'((32'(size) + 32'(PAGE_BYTES - 1)) >> OFFSET_BITS);
            vaddr_reg  <= ADDRESS_BITS'(32'(address));
            wdata_reg  <= write_data;
            status_reg <= ST_OK;
            region_reg <= 16'd0;
            rbyte_reg  <= 8'd0;
        end
        if (cmd.decode)
        begin
            if (op_reg == OP_ALLOC)
            begin
                if (alloc_ok)
                begin
                    region_reg <= brk_cur[15:0];
                    frame_reg  <= '0;
                    n_reg      <= '0;
                    vpn_reg    <= VPN_BITS'(brk_cur >> OFFSET_BITS);
                end
                else
                    status_reg <= ST_REFUSED;
            end
            else if (!pid_ok)
                status_reg <= ST_UNMAPPED;
        end
        if (cmd.xlat)
        begin
            if (!map_q[FRAME_BITS])
                status_reg <= ST_UNMAPPED;
            else if (op_reg == OP_FREE)
            begin
                frame_reg <= map_q[FRAME_BITS-1:0];
                k_reg     <= '0;
                vpn_reg   <= vpn_in;
            end
        end
        if (cmd.mem_cap)
            rbyte_reg <= ram_q;
        if (cmd.scan_chk)
        begin
            frame_reg <= frame_reg + FRAME_BITS'(1);
            if (owner_free)
            begin
                prev_reg <= frame_reg;
                n_reg    <= n_reg + CNT_BITS'(1);
                vpn_reg  <= vpn_reg + VPN_BITS'(1);
            end
        end
        if (cmd.free_chk)
        begin
            frame_reg <= link_q[FRAME_BITS-1:0];
            k_reg     <= k_reg + FRAME_BITS'(1);
            vpn_reg   <= vpn_reg + VPN_BITS'(1);
        end
    end

endmodule

// File: rtl/core/pmm_ctrl.sv
// Controller: request sequencing state machine.
module pmm_ctrl
    import pmm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    input  sts_t sts,
    output cmd_t cmd,
    output logic busy,
    output logic done
);

    typedef enum logic [10:0] {
        S_CLEAR    = 11'b000_0000_0001,
        S_IDLE     = 11'b000_0000_0010,
        S_DECODE   = 11'b000_0000_0100,
        S_XLAT     = 11'b000_0000_1000,
        S_MEM      = 11'b000_0001_0000,
        S_SCAN_RD  = 11'b000_0010_0000,
        S_SCAN_CHK = 11'b000_0100_0000,
        S_LINK     = 11'b000_1000_0000,
        S_FREE_RD  = 11'b001_0000_0000,
        S_FREE_CHK = 11'b010_0000_0000,
        S_RESP     = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:    if (sts.clear_done) state_next = S_IDLE;
            S_IDLE:     if (start) state_next = S_DECODE;
            S_DECODE:
            begin
                if (sts.op == OP_ALLOC)
                    state_next = sts.alloc_ok ? S_SCAN_RD : S_RESP;
                else
                    state_next = sts.pid_ok ? S_XLAT : S_RESP;
            end
            S_XLAT:
            begin
                if (!sts.map_valid)
                    state_next = S_RESP;
                else
                begin
                    case (sts.op)
                        OP_FREE: state_next = S_FREE_RD;
                        OP_READ: state_next = S_MEM;
                        default: state_next = S_RESP;
                    endcase
                end
            end
            S_MEM:      state_next = S_RESP;
            S_SCAN_RD:  state_next = S_SCAN_CHK;
            S_SCAN_CHK: state_next = sts.scan_last ? S_LINK : S_SCAN_RD;
            S_LINK:     state_next = S_RESP;
            S_FREE_RD:  state_next = S_FREE_CHK;
            S_FREE_CHK: state_next = sts.free_last ? S_RESP : S_FREE_RD;
            S_RESP:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_CLEAR;
        else
            state_reg <= state_next;
    end

    assign cmd.clear    = (state_reg == S_CLEAR);
    assign cmd.latch    = (state_reg == S_IDLE) && start;
    assign cmd.decode   = (state_reg == S_DECODE);
    assign cmd.xlat     = (state_reg == S_XLAT);
    assign cmd.mem_cap  = (state_reg == S_MEM);
    assign cmd.scan_chk = (state_reg == S_SCAN_CHK);
    assign cmd.link_end = (state_reg == S_LINK);
    assign cmd.free_rd  = (state_reg == S_FREE_RD);
    assign cmd.free_chk = (state_reg == S_FREE_CHK);

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_RESP);

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("controller state not one-hot");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted request did not start processing");

endmodule

// File: rtl/core/paged_memory_manager_core.sv
// Top level: paged memory manager, controller plus datapath.
// Allocate scans the frames in order; free walks the chained frames (at most FRAME_COUNT).
// Throughput: one request at a time; the next is taken the cycle after done.
// Reset: a clearing pass zeroes RAM, map and frame owners; busy stays high meanwhile.
module paged_memory_manager_core
    import pmm_pkg::*;
#(
    parameter int OFFSET_BITS   = OFFSET_BITS_DEF,
    parameter int ADDRESS_BITS  = ADDRESS_BITS_DEF,
    parameter int FRAME_COUNT   = FRAME_COUNT_DEF,
    parameter int PROCESS_SLOTS = PROCESS_SLOTS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [3:0]  pid,
    input  logic [16:0] size,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    output logic        done,
    output logic [1:0]  status,
    output logic [15:0] region_start,
    output logic [7:0]  read_byte
);

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    pmm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    pmm_datapath #(
        .OFFSET_BITS   (OFFSET_BITS),
        .ADDRESS_BITS  (ADDRESS_BITS),
        .FRAME_COUNT   (FRAME_COUNT),
        .PROCESS_SLOTS (PROCESS_SLOTS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .op           (op),
        .pid          (pid),
        .size         (size),
        .address      (address),
        .write_data   (write_data),
        .cmd          (cmd),
        .sts          (sts),
        .status       (status),
        .region_start (region_start),
        .read_byte    (read_byte)
    );

endmodule

// File: test/paged_memory_manager_core_checker.sv
`timescale 1ns / 1ps
// Checker: predicts each paged memory manager response and compares it with the block.
module paged_memory_manager_core_checker
    import pmm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [16:0] cfg_data,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  op,
    input  logic [3:0]  pid,
    input  logic [16:0] size,
    input  logic [15:0] address,
    input  logic [7:0]  write_data,
    input  logic        done,
    input  logic [1:0]  status,
    input  logic [15:0] region_start,
    input  logic [7:0]  read_byte,
    output int          errors,
    output int          outstanding
);

    typedef struct {
        status_t     st;
        logic [15:0] region;
        logic [7:0]  rdata;
    } response_t;

    logic [7:0]  mem_bytes [65536];
    logic [3:0]  frame_pid [256];
    logic [8:0]  frame_next [256];
    logic [16:0] brk [16];
    logic [8:0]  vmap [4096];
    response_t   pending_q [$];

    initial
    begin
        for (int i = 0; i < 65536; i++)
            mem_bytes[i] = 8'd0;
        for (int i = 0; i < 256; i++)
        begin
            frame_pid[i] = 4'd0;
            frame_next[i] = 9'd0;
        end
        for (int i = 0; i < 4096; i++)
            vmap[i] = 9'd0;
        for (int i = 0; i < 16; i++)
            brk[i] = INIT_BREAK;
        errors = 0;
        outstanding = 0;
    end

    function automatic response_t serve(op_t o, logic [3:0] p, logic [16:0] sz,
                                        logic [15:0] a, logic [7:0] wd);
        response_t r;
        int pages;
        int nfree;
        int n;
        int prev;
        int frame;
        logic [8:0] e;
        logic [8:0] lnk;
        logic [16:0] base;
        r.st = ST_OK;
        r.region = 16'd0;
        r.rdata = 8'd0;
        if (o == OP_ALLOC)
        begin
            pages = (int'(sz) + 255) >> 8;
            if (p == 4'd0 || pages == 0)
            begin
                r.st = ST_REFUSED;
                return r;
            end
            nfree = 0;
            for (int f = 0; f < 256; f++)
                if (frame_pid[f] == 4'd0)
                    nfree++;
            if (nfree < pages || int'(brk[p]) + (pages << 8) > 65536)
            begin
                r.st = ST_REFUSED;
                return r;
            end
            base = brk[p];
            brk[p] = base + 17'(pages << 8);
            n = 0;
            prev = 0;
            for (int f = 0; f < 256 && n < pages; f++)
            begin
                if (frame_pid[f] != 4'd0)
                    continue;
                frame_pid[f] = p;
                if (n > 0)
                    frame_next[prev] = 9'(f);
                vmap[p * 256 + ((int'(base[15:8]) + n) & 255)] = {1'b1, 8'(f)};
                prev = f;
                n++;
            end
            frame_next[prev] = 9'h100;
            r.region = base[15:0];
            return r;
        end
        if (p == 4'd0)
        begin
            r.st = ST_UNMAPPED;
            return r;
        end
        e = vmap[p * 256 + a[15:8]];
        if (!e[8])
        begin
            r.st = ST_UNMAPPED;
            return r;
        end
        case (o)
            OP_FREE:
            begin
                frame = e[7:0];
                for (int k = 0; k < 256; k++)
                begin
                    frame_pid[frame] = 4'd0;
                    vmap[p * 256 + ((int'(a[15:8]) + k) & 255)] = 9'd0;
                    lnk = frame_next[frame];
                    if (lnk[8])
                        break;
                    frame = lnk[7:0];
                end
            end
            OP_READ:  r.rdata = mem_bytes[{e[7:0], a[7:0]}];
            default:  mem_bytes[{e[7:0], a[7:0]}] = wd;
        endcase
        return r;
    endfunction

    always @(posedge clk)
    begin
        response_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("%0t: response with nothing expected: st=%0d rs=%h rb=%h",
                                 $realtime, status, region_start, read_byte);
                    errors <= errors + 1;
                end
                else
                begin
                    want = pending_q.pop_front();
                    if (status !== want.st || region_start !== want.region ||
                        read_byte !== want.rdata)
                    begin
                        if (errors < 10)
                            $display("%0t: mismatch exp st=%0d rs=%h rb=%h got st=%0d rs=%h rb=%h",
                                     $realtime, want.st, want.region, want.rdata,
                                     status, region_start, read_byte);
                        errors <= errors + 1;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                for (int i = 0; i < 16; i++)
                    brk[i] = cfg_data;
            if (start && !busy)
                pending_q.push_back(serve(op_t'(op), pid, size, address, write_data));
            outstanding <= pending_q.size();
        end
    end

endmodule

// File: test/paged_memory_manager_core_test.sv
`timescale 1ns / 1ps
// Testbench top: drives requests and break settings into the paged memory manager.
module paged_memory_manager_core_test;
    import pmm_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [16:0] cfg_data;
    logic        start;
    logic        busy;
    logic [1:0]  op;
    logic [3:0]  pid;
    logic [16:0] size;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic        done;
    logic [1:0]  status;
    logic [15:0] region_start;
    logic [7:0]  read_byte;
    int          errors;
    int          outstanding;

    logic        no_gaps;
    op_t         last_op;
    logic [3:0]  last_pid;
    logic [3:0]  region_pid [$];
    logic [15:0] region_base [$];

    logic [16:0] break_values [6] = '{17'd256, 17'd0, 17'd65536, 17'd65280, 17'd1024, 17'd0};

    paged_memory_manager_core uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .start(start), .busy(busy),
        .op(op), .pid(pid), .size(size), .address(address), .write_data(write_data),
        .done(done), .status(status), .region_start(region_start), .read_byte(read_byte)
    );

    paged_memory_manager_core_checker u_check (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .start(start), .busy(busy),
        .op(op), .pid(pid), .size(size), .address(address), .write_data(write_data),
        .done(done), .status(status), .region_start(region_start), .read_byte(read_byte),
        .errors(errors), .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // remember granted regions so later beats can hit mapped pages
    always @(posedge clk)
    begin
        if (rst_n && done && last_op == OP_ALLOC && status == ST_OK && region_pid.size() < 64)
        begin
            region_pid.push_back(last_pid);
            region_base.push_back(region_start);
        end
        if (rst_n && start && !busy)
        begin
            last_op  <= op_t'(op);
            last_pid <= pid;
        end
    end

    task automatic gap();
        if (!no_gaps && $urandom_range(0, 99) < 29)
            repeat ($urandom_range(1, 4)) @(negedge clk);
    endtask

    task automatic issue(op_t o, logic [3:0] p, logic [16:0] sz, logic [15:0] a,
                         logic [7:0] wd);
        logic ok;
        gap();
        op = o;
        pid = p;
        size = sz;
        address = a;
        write_data = wd;
        start = 1'b1;
        forever
        begin
            ok = !busy;
            @(posedge clk);
            @(negedge clk);
            if (ok)
                break;
        end
        start = 1'b0;
    endtask

    task automatic drain();
        while (outstanding != 0 || busy)
            @(negedge clk);
        repeat (600) @(negedge clk);
    endtask

    task automatic write_break(logic [16:0] v);
        logic ok;
        gap();
        cfg_data = v;
        cfg_valid = 1'b1;
        forever
        begin
            ok = cfg_ready;
            @(posedge clk);
            @(negedge clk);
            if (ok)
                break;
        end
        cfg_valid = 1'b0;
    endtask

    task automatic random_item();
        int          r;
        int          k;
        op_t         o;
        logic [3:0]  p;
        logic [16:0] sz;
        logic [15:0] a;
        r = $urandom_range(0, 99);
        o = r < 30 ? OP_ALLOC : r < 50 ? OP_FREE : r < 75 ? OP_READ : OP_WRITE;
        p = $urandom_range(0, 19) == 0 ? 4'd0 : 4'($urandom_range(1, 15));
        a = 16'($urandom);
        r = $urandom_range(0, 99);
        sz = r < 80 ? 17'($urandom_range(1, 1024)) : r < 90 ? 17'($urandom_range(1, 8192)) :
             r < 95 ? 17'd0 : 17'($urandom_range(0, 131071));
        if (o != OP_ALLOC && region_pid.size() > 0 && $urandom_range(0, 99) < 80)
        begin
            k = $urandom_range(0, region_pid.size() - 1);
            p = region_pid[k];
            if (o == OP_FREE)
                a = region_base[k] + 16'($urandom_range(0, 1) * 256 + $urandom_range(0, 255));
            else
                a = region_base[k] + 16'($urandom_range(0, 767));
            if (o == OP_FREE && $urandom_range(0, 1) == 0)
            begin
                region_pid.delete(k);
                region_base.delete(k);
            end
        end
        issue(o, p, sz, a, 8'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 17'd0;
        start = 1'b0;
        op = OP_ALLOC;
        pid = 4'd0;
        size = 17'd0;
        address = 16'd0;
        write_data = 8'd0;
        no_gaps = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (busy)
            @(negedge clk);

        issue(OP_ALLOC, 4'd1, 17'd0, 16'd0, 8'd0);
        issue(OP_ALLOC, 4'd0, 17'd100, 16'd0, 8'd0);
        issue(OP_READ, 4'd1, 17'd0, 16'd256, 8'd0);
        issue(OP_ALLOC, 4'd1, 17'd1, 16'd0, 8'd0);
        issue(OP_WRITE, 4'd1, 17'd0, 16'd256, 8'hFF);
        issue(OP_READ, 4'd1, 17'd0, 16'd256, 8'd0);
        issue(OP_WRITE, 4'd1, 17'd0, 16'd511, 8'h00);
        issue(OP_READ, 4'd1, 17'd0, 16'd511, 8'd0);
        issue(OP_ALLOC, 4'd15, 17'd65536, 16'd0, 8'd0);
        issue(OP_ALLOC, 4'd2, 17'd300, 16'd0, 8'd0);
        issue(OP_WRITE, 4'd2, 17'd0, 16'd600, 8'hA5);
        issue(OP_FREE, 4'd2, 17'd0, 16'd530, 8'd0);
        issue(OP_READ, 4'd2, 17'd0, 16'd600, 8'd0);
        issue(OP_READ, 4'd2, 17'd0, 16'd300, 8'd0);
        issue(OP_FREE, 4'd0, 17'd0, 16'd256, 8'd0);
        issue(OP_WRITE, 4'd0, 17'd0, 16'd256, 8'h5A);
        issue(OP_READ, 4'd1, 17'd0, 16'hFFFF, 8'd0);
        issue(OP_ALLOC, 4'd3, 17'd65280, 16'd0, 8'd0);
        issue(OP_ALLOC, 4'd3, 17'd65024, 16'd0, 8'd0);
        issue(OP_FREE, 4'd3, 17'd0, 16'd256, 8'd0);
        issue(OP_FREE, 4'd1, 17'd0, 16'd256, 8'd0);
        issue(OP_FREE, 4'd1, 17'd0, 16'd256, 8'd0);
        issue(OP_WRITE, 4'd15, 17'd0, 16'd0, 8'hFF);

        for (int ph = 0; ph < 6; ph++)
        begin
            drain();
            write_break(break_values[ph] == 17'd1024 ? 17'($urandom_range(0, 65535))
                                                     : break_values[ph]);
            no_gaps = (ph == 2);
            for (int i = 0; i < 255; i++)
                random_item();
        end
        no_gaps = 1'b0;

        while (outstanding != 0)
            @(negedge clk);
        repeat (600) @(negedge clk);
        if (errors == 0 && outstanding == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/pmm_pkg.sv
rtl/core/pmm_datapath.sv
rtl/core/pmm_ctrl.sv
rtl/core/paged_memory_manager_core.sv
test/paged_memory_manager_core_checker.sv
test/paged_memory_manager_core_test.sv
